/* hdl/u7e_pkg.sv */
// Shared types, constants and base64 helpers for the UCS-2 to UTF-7 encoder.
`timescale 1ns / 1ps
`default_nettype none

package u7e_pkg;

    // Character codes used by the encoder.
    localparam logic [6:0]  CHAR_PLUS  = 7'h2B;
    localparam logic [6:0]  CHAR_MINUS = 7'h2D;
    localparam logic [6:0]  CHAR_UPPER_A = 7'h41;
    localparam logic [6:0]  CHAR_LOWER_A = 7'h61;
    localparam logic [6:0]  CHAR_DIGIT_0 = 7'h30;
    localparam logic [6:0]  CHAR_SLASH = 7'h2F;

    // Base64 digit range limits.
    localparam logic [5:0]  B64_UPPER_LAST = 6'h19;
    localparam logic [5:0]  B64_LOWER_FIRST = 6'h1A;
    localparam logic [5:0]  B64_LOWER_LAST = 6'h33;
    localparam logic [5:0]  B64_DIGIT_FIRST = 6'h34;
    localparam logic [5:0]  B64_DIGIT_LAST = 6'h3D;
    localparam logic [5:0]  B64_PLUS = 6'h3E;

    // Leftover bit counts carried between units of a run.
    localparam logic [2:0]  CARRY_NONE = 3'd0;
    localparam logic [2:0]  CARRY_TWO  = 3'd2;
    localparam logic [2:0]  CARRY_FOUR = 3'd4;

    // Burst geometry.
    localparam int          MAX_BURST = 5;
    localparam logic [2:0]  BURST_MAX_COUNT = 3'd5;
    localparam int          QUEUE_DEPTH = 2;
    localparam logic [1:0]  QUEUE_FULL_COUNT = 2'd2;

    // All characters caused by one code unit, in emission order.
    typedef struct packed {
        logic [MAX_BURST-1:0][6:0] chars;
        logic [2:0]                count;
    } burst_t;

    // Push side of the queue as seen by the front end.
    typedef struct packed {
        logic   valid;
        burst_t burst;
    } push_t;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic   valid;
        burst_t burst;
    } head_t;

    // Map a 6-bit value onto its base64 character.
    function automatic logic [6:0] b64_digit(input logic [5:0] v);
        logic [6:0] ch;
        if (v <= B64_UPPER_LAST) begin
            ch = CHAR_UPPER_A + {1'b0, v};
        end
        else if (v <= B64_LOWER_LAST) begin
            ch = CHAR_LOWER_A + {1'b0, v - B64_LOWER_FIRST};
        end
        else if (v <= B64_DIGIT_LAST) begin
            ch = CHAR_DIGIT_0 + {1'b0, v - B64_DIGIT_FIRST};
        end
        else if (v == B64_PLUS) begin
            ch = CHAR_PLUS;
        end
        else begin
            ch = CHAR_SLASH;
        end
        return ch;
    endfunction

    // Pad the leftover bits with zeros into one final digit.
    function automatic logic [6:0] flush_digit(input logic [3:0] bits,
                                               input logic [2:0] cnt);
        logic [5:0] v;
        if (cnt == CARRY_FOUR) begin
            v = {bits, 2'b00};
        end
        else begin
            v = {bits[1:0], 4'b0000};
        end
        return b64_digit(v);
    endfunction

endpackage

`default_nettype wire

/* hdl/ucs2_to_utf7_encoder_top.sv */
// A code unit's characters pass through a queue entry and then the output register before they appear.
// One character per cycle while char_stall is low, set by the single-character output register; a unit
// yields one to five characters (two or three when it continues an open run and does not end the string).
// A two-entry burst queue lets input transactions run ahead while the output stalls.
// Reset (rst_n low, asynchronous) closes any run, clears leftover bits and empties the queue.
// Top level of the UCS-2 to UTF-7 encoder.
`timescale 1ns / 1ps
`default_nettype none

module ucs2_to_utf7_encoder_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           unit_valid,
    output logic                unit_stall,
    input  wire logic [15:0]    code_unit,
    input  wire logic           end_of_text,
    output logic                char_valid,
    input  wire logic           char_stall,
    output logic [6:0]          out_char,
    output logic                last_of_burst
);

    u7e_pkg::push_t push;
    u7e_pkg::head_t head;
    logic           queue_full;
    logic           pop;

    // Classify units and build bursts.
    u7e_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .unit_valid  (unit_valid),
        .unit_stall  (unit_stall),
        .code_unit   (code_unit),
        .end_of_text (end_of_text),
        .queue_full  (queue_full),
        .push        (push)
    );

    // Decouple the front end from the emitter.
    u7e_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .head  (head),
        .pop   (pop)
    );

    // Emit characters one per cycle while the output is not stalled.
    u7e_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .out_char      (out_char),
        .last_of_burst (last_of_burst)
    );

endmodule

`default_nettype wire

/* hdl/u7e_front.sv */
// Front end: accepts code units, tracks the base64 run and builds each character burst.
`timescale 1ns / 1ps
`default_nettype none

module u7e_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           unit_valid,
    output logic                unit_stall,
    input  wire logic [15:0]    code_unit,
    input  wire logic           end_of_text,
    input  wire logic           queue_full,
    output u7e_pkg::push_t      push
);

    logic           in_shift_reg;
    logic           in_shift_next;
    logic [3:0]     carry_bits_reg;
    logic [3:0]     carry_bits_next;
    logic [2:0]     carry_count_reg;
    logic [2:0]     carry_count_next;
    u7e_pkg::burst_t burst;
    logic [2:0]     put_cnt;
    logic           accept;

    assign unit_stall = queue_full;
    assign accept     = unit_valid && !queue_full;

    // Build the burst for the offered unit and the run state that follows it.
    always_comb
    begin
        burst            = '0;
        put_cnt          = 3'd0;
        in_shift_next    = in_shift_reg;
        carry_bits_next  = carry_bits_reg;
        carry_count_next = carry_count_reg;

        if (code_unit[15:7] == 9'd0) begin
            // An ASCII unit closes any open run first.
            if (in_shift_reg) begin
                if (carry_count_reg != u7e_pkg::CARRY_NONE) begin
                    burst.chars[put_cnt] = u7e_pkg::flush_digit(carry_bits_reg,
                                                                carry_count_reg);
                    put_cnt = put_cnt + 3'd1;
                end
                burst.chars[put_cnt] = u7e_pkg::CHAR_MINUS;
                put_cnt = put_cnt + 3'd1;
            end
            in_shift_next    = 1'b0;
            carry_bits_next  = 4'd0;
            carry_count_next = u7e_pkg::CARRY_NONE;
            if (code_unit[6:0] == u7e_pkg::CHAR_PLUS) begin
                burst.chars[put_cnt] = u7e_pkg::CHAR_PLUS;
                put_cnt = put_cnt + 3'd1;
                burst.chars[put_cnt] = u7e_pkg::CHAR_MINUS;
                put_cnt = put_cnt + 3'd1;
            end
            else begin
                burst.chars[put_cnt] = code_unit[6:0];
                put_cnt = put_cnt + 3'd1;
            end
        end
        else begin
            // A unit above ASCII opens a run if none is open.
            if (!in_shift_reg) begin
                burst.chars[put_cnt] = u7e_pkg::CHAR_PLUS;
                put_cnt = put_cnt + 3'd1;
            end
            in_shift_next = 1'b1;
            // Pack the carried bits and the unit big-endian into digits.
            if (!in_shift_reg || carry_count_reg == u7e_pkg::CARRY_NONE) begin
                burst.chars[put_cnt] = u7e_pkg::b64_digit(code_unit[15:10]);
                put_cnt = put_cnt + 3'd1;
                burst.chars[put_cnt] = u7e_pkg::b64_digit(code_unit[9:4]);
                put_cnt = put_cnt + 3'd1;
                carry_bits_next  = code_unit[3:0];
                carry_count_next = u7e_pkg::CARRY_FOUR;
            end
            else if (carry_count_reg == u7e_pkg::CARRY_FOUR) begin
                burst.chars[put_cnt] = u7e_pkg::b64_digit({carry_bits_reg,
                                                           code_unit[15:14]});
                put_cnt = put_cnt + 3'd1;
                burst.chars[put_cnt] = u7e_pkg::b64_digit(code_unit[13:8]);
                put_cnt = put_cnt + 3'd1;
                burst.chars[put_cnt] = u7e_pkg::b64_digit(code_unit[7:2]);
                put_cnt = put_cnt + 3'd1;
                carry_bits_next  = {2'b00, code_unit[1:0]};
                carry_count_next = u7e_pkg::CARRY_TWO;
            end
            else begin
                burst.chars[put_cnt] = u7e_pkg::b64_digit({carry_bits_reg[1:0],
                                                           code_unit[15:12]});
                put_cnt = put_cnt + 3'd1;
                burst.chars[put_cnt] = u7e_pkg::b64_digit(code_unit[11:6]);
                put_cnt = put_cnt + 3'd1;
                burst.chars[put_cnt] = u7e_pkg::b64_digit(code_unit[5:0]);
                put_cnt = put_cnt + 3'd1;
                carry_bits_next  = 4'd0;
                carry_count_next = u7e_pkg::CARRY_NONE;
            end
            // The end of the string closes the run in the same transaction.
            if (end_of_text) begin
                if (carry_count_next != u7e_pkg::CARRY_NONE) begin
                    burst.chars[put_cnt] = u7e_pkg::flush_digit(carry_bits_next,
                                                                carry_count_next);
                    put_cnt = put_cnt + 3'd1;
                end
                burst.chars[put_cnt] = u7e_pkg::CHAR_MINUS;
                put_cnt = put_cnt + 3'd1;
                in_shift_next    = 1'b0;
                carry_bits_next  = 4'd0;
                carry_count_next = u7e_pkg::CARRY_NONE;
            end
        end
        burst.count = put_cnt;
    end

    // Push the finished burst into the queue.
    assign push.valid = accept;
    assign push.burst = burst;

    // Run state advances only on an accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_shift_reg    <= 1'b0;
            carry_bits_reg  <= 4'd0;
            carry_count_reg <= u7e_pkg::CARRY_NONE;
        end
        else if (accept) begin
            in_shift_reg    <= in_shift_next;
            carry_bits_reg  <= carry_bits_next;
            carry_count_reg <= carry_count_next;
        end
    end

`ifndef SYNTHESIS
    // Every transaction yields between one and five characters.
    a_burst_size: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (burst.count != 3'd0 && burst.count <= u7e_pkg::BURST_MAX_COUNT))
        else $error("burst size out of range");

    // Leftover bits come only in pairs, and only inside a run.
    a_carry_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (carry_count_reg == u7e_pkg::CARRY_NONE)
        || (in_shift_reg && (carry_count_reg == u7e_pkg::CARRY_TWO
                             || carry_count_reg == u7e_pkg::CARRY_FOUR)))
        else $error("illegal carry state");

    // The end of the string leaves the run state as it is after reset.
    a_eot_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_text) |=> (!in_shift_reg && carry_count_reg == u7e_pkg::CARRY_NONE
                                     && carry_bits_reg == 4'd0))
        else $error("run not closed at end of text");
`endif

endmodule

`default_nettype wire

/* hdl/u7e_queue.sv */
// Two-entry burst queue between the front end and the character emitter.
`timescale 1ns / 1ps
`default_nettype none

module u7e_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  u7e_pkg::push_t      push,
    output logic                full,
    output u7e_pkg::head_t      head,
    input  wire logic           pop
);

    u7e_pkg::burst_t entries [u7e_pkg::QUEUE_DEPTH];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            do_push;
    logic            do_pop;

    assign full       = (count_reg == u7e_pkg::QUEUE_FULL_COUNT);
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.burst = entries[rd_ptr_reg];

    // Occupancy after this cycle's push and pop.
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // Entry storage, written at the write pointer.
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push.burst;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    // Occupancy never exceeds the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= u7e_pkg::QUEUE_FULL_COUNT)
        else $error("queue overflow");
`endif

endmodule

`default_nettype wire

/* hdl/u7e_back.sv */
// Back end: steps through the head burst and drives one character per cycle unless char_stall holds the output.
`timescale 1ns / 1ps
`default_nettype none

module u7e_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  u7e_pkg::head_t      head,
    output logic                pop,
    output logic                char_valid,
    input  wire logic           char_stall,
    output logic [6:0]          out_char,
    output logic                last_of_burst
);

    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       valid_reg;
    logic       valid_next;
    logic [6:0] char_reg;
    logic       last_reg;
    logic       load;
    logic       is_last;

    // The output register takes a new character when it is empty or being taken.
    assign load    = head.valid && (!valid_reg || !char_stall);
    assign is_last = (idx_reg == head.burst.count - 3'd1);
    assign pop     = load && is_last;

    // Character index and output valid.
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = is_last ? 3'd0 : idx_reg + 3'd1;
        end
        else if (!char_stall) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load) begin
            char_reg <= head.burst.chars[idx_reg];
            last_reg <= is_last;
        end
    end

    assign char_valid    = valid_reg;
    assign out_char      = char_reg;
    assign last_of_burst = last_reg;

`ifndef SYNTHESIS
    // The index always points inside the head burst.
    a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> (idx_reg < head.burst.count))
        else $error("character index beyond burst");

    // The index rewinds when the head burst is retired.
    a_idx_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == 3'd0))
        else $error("index not rewound after pop");
`endif

endmodule

`default_nettype wire
